// ===== design/mlo_pkg.sv =====
package mlo_pkg;

  localparam int ANGLE_W = 32;
  localparam int CS_W    = 34;
  localparam int CNT_W   = 5;
  localparam int ATAN_N  = 30;
  localparam int OUT_W   = 16;
  localparam int SENS_W  = 24;
  localparam int LIMIT_W = 30;
  localparam int CFG_W   = 32;

  localparam logic [1:0] CMD_UPDATE  = 2'd0;
  localparam logic [1:0] CMD_CAPTURE = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ENABLE  = 2'd1;
  localparam logic [1:0] ACT_DISABLE = 2'd2;

  localparam logic REG_SENSITIVITY = 1'b0;
  localparam logic REG_PITCH_LIMIT = 1'b1;

  localparam logic [SENS_W-1:0]  SENS_RESET  = 24'd1193046;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd1061811359;

  localparam logic signed [CS_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_UPDATE,
    ST_CY_START,
    ST_CY_WAIT,
    ST_CP_START,
    ST_CP_WAIT,
    ST_MUL_SC,
    ST_MUL_CC,
    ST_PROD_CC,
    ST_FINISH
  } st_t;

  function automatic logic [LIMIT_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [LIMIT_W-1:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/mlo_mul.sv =====
module mlo_mul (
  input  logic                clk,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [63:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== design/mlo_cordic.sv =====
module mlo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [mlo_pkg::ANGLE_W-1:0]          angle,
  output logic                                 done,
  output logic signed [mlo_pkg::CS_W-1:0]      cos_val,
  output logic signed [mlo_pkg::CS_W-1:0]      sin_val
);

  localparam logic [mlo_pkg::CNT_W-1:0] LAST = mlo_pkg::CNT_W'(CORDIC_STEPS - 1);

  logic signed [mlo_pkg::CS_W-1:0] x_r, y_r, z_r;
  logic signed [mlo_pkg::CS_W-1:0] x_nxt, y_nxt, z_nxt, z0;
  logic signed [mlo_pkg::CS_W-1:0] xs, ys, at;
  logic [1:0] q_r, q_in;
  logic [mlo_pkg::CNT_W-1:0] cnt_r;
  logic run_r, done_r;
  logic [mlo_pkg::ANGLE_W-1:0] sum, rem;

  // nearest quarter turn and remainder
  always_comb begin
    sum  = angle + mlo_pkg::EIGHTH_TURN;
    q_in = sum[31:30];
    rem  = angle - {q_in, 30'b0};
    z0   = {{2{rem[31]}}, rem};
  end

  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = {4'b0, mlo_pkg::atan_turn(cnt_r)};
    if (!z_r[mlo_pkg::CS_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= mlo_pkg::CORDIC_X0;
      y_r <= '0;
      z_r <= z0;
      q_r <= q_in;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    unique case (q_r)
      2'd0: begin cos_val = x_r;  sin_val = y_r;  end
      2'd1: begin cos_val = -y_r; sin_val = x_r;  end
      2'd2: begin cos_val = -x_r; sin_val = -y_r; end
      2'd3: begin cos_val = y_r;  sin_val = -x_r; end
    endcase
  end

  assign done = done_r;

endmodule

// ===== design/mouse_look_orientation_core.sv =====
// Mouse-look camera orientation. Each request runs through a small sequencer
// that drives the single iterative CORDIC, which runs one step per cycle,
// first for yaw and then for pitch, and makes passes through one shared
// 32x32 multiplier for the mouse deltas and the cos(pitch) products. in_ready
// is high only while the sequencer is idle. A finished result waits in the
// output register, so the next request can be accepted before it is taken.
// Configuration writes are always taken and must only be issued while the
// block is idle.
module mouse_look_orientation_core #(
  parameter int CORDIC_STEPS     = 16,
  parameter int VECTOR_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [mlo_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic signed [15:0]            in_delta_x,
  input  logic signed [15:0]            in_delta_y,
  input  logic                          in_escape_pressed,
  input  logic                          in_left_pressed,
  input  logic                          in_capture_value,
  input  logic signed [31:0]            in_load_yaw,
  input  logic signed [31:0]            in_load_pitch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_capture_action,
  output logic                          out_capture_on,
  output logic signed [31:0]            out_yaw_out,
  output logic signed [31:0]            out_pitch_out,
  output logic signed [15:0]            out_forward_x,
  output logic signed [15:0]            out_forward_y,
  output logic signed [15:0]            out_forward_z
);

  localparam int SH     = 30 - VECTOR_FRAC_BITS;
  localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< RND_SH) : 36'sd0;
  localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

  mlo_pkg::st_t st_r, st_nxt;

  logic [mlo_pkg::SENS_W-1:0]  sens_r;
  logic [mlo_pkg::LIMIT_W-1:0] lim_r;
  logic [31:0] yaw_r, pitch_r;
  logic flag_r, upd_r;
  logic [1:0] cmd_r, act_r;
  logic signed [15:0] dx_r, dy_r;
  logic signed [31:0] ly_r, lp_r;
  logic signed [mlo_pkg::CS_W-1:0] cy_r, sy_r, cp_r, sp_r;
  logic signed [15:0] fx_r, fz_r;
  logic out_valid_r;
  logic [1:0] oact_r;
  logic ocap_r;
  logic [31:0] oyaw_r, opitch_r;
  logic signed [15:0] ofx_r, ofy_r, ofz_r;

  logic accept, out_load, cordic_start, cordic_done, pick_pitch;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r, prod_rnd, pitch_upd;
  logic signed [33:0] q30;
  logic signed [35:0] q30_ext;
  logic [31:0] cordic_angle;
  logic signed [mlo_pkg::CS_W-1:0] c_val, s_val;

  function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + RND) >>> SH;
    if (t > 36'sd32767) return 16'sh7FFF;
    else if (t < -36'sd32768) return 16'sh8000;
    else return t[15:0];
  endfunction

  function automatic logic [31:0] clamp_pitch(input logic signed [63:0] p,
                                              input logic [mlo_pkg::LIMIT_W-1:0] lim);
    logic signed [63:0] l;
    l = {34'b0, lim};
    if (p > l) return l[31:0];
    else if (p < -l) return 32'(-l);
    else return p[31:0];
  endfunction

  mlo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  mlo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .done    (cordic_done),
    .cos_val (c_val),
    .sin_val (s_val)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mlo_pkg::ST_IDLE:     if (in_valid) st_nxt = mlo_pkg::ST_MUL_X;
      mlo_pkg::ST_MUL_X:    st_nxt = mlo_pkg::ST_MUL_Y;
      mlo_pkg::ST_MUL_Y:    st_nxt = mlo_pkg::ST_UPDATE;
      mlo_pkg::ST_UPDATE:   st_nxt = mlo_pkg::ST_CY_START;
      mlo_pkg::ST_CY_START: st_nxt = mlo_pkg::ST_CY_WAIT;
      mlo_pkg::ST_CY_WAIT:  if (cordic_done) st_nxt = mlo_pkg::ST_CP_START;
      mlo_pkg::ST_CP_START: st_nxt = mlo_pkg::ST_CP_WAIT;
      mlo_pkg::ST_CP_WAIT:  if (cordic_done) st_nxt = mlo_pkg::ST_MUL_SC;
      mlo_pkg::ST_MUL_SC:   st_nxt = mlo_pkg::ST_MUL_CC;
      mlo_pkg::ST_MUL_CC:   st_nxt = mlo_pkg::ST_PROD_CC;
      mlo_pkg::ST_PROD_CC:  st_nxt = mlo_pkg::ST_FINISH;
      mlo_pkg::ST_FINISH:   if (!out_valid_r || out_ready) st_nxt = mlo_pkg::ST_IDLE;
      default:              st_nxt = mlo_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = (st_r == mlo_pkg::ST_IDLE);
    cordic_start = (st_r == mlo_pkg::ST_CY_START) || (st_r == mlo_pkg::ST_CP_START);
    pick_pitch   = (st_r == mlo_pkg::ST_CP_START);
    out_load     = (st_r == mlo_pkg::ST_FINISH) && (!out_valid_r || out_ready);
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      mlo_pkg::ST_MUL_X: begin
        mul_a = {{16{dx_r[15]}}, dx_r};
        mul_b = {8'b0, sens_r};
      end
      mlo_pkg::ST_MUL_Y: begin
        mul_a = {{16{dy_r[15]}}, dy_r};
        mul_b = {8'b0, sens_r};
      end
      mlo_pkg::ST_MUL_SC: begin
        mul_a = sy_r[31:0];
        mul_b = cp_r[31:0];
      end
      mlo_pkg::ST_MUL_CC: begin
        mul_a = cy_r[31:0];
        mul_b = cp_r[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign accept       = in_valid && in_ready;
  assign cfg_ready    = 1'b1;
  assign cordic_angle = pick_pitch ? pitch_r : yaw_r;
  assign prod_rnd     = prod_r + Q30_HALF;
  assign q30          = prod_rnd[63:30];
  assign q30_ext      = {{2{q30[33]}}, q30};
  assign pitch_upd    = {{32{pitch_r[31]}}, pitch_r} - prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mlo_pkg::ST_IDLE;
      sens_r      <= mlo_pkg::SENS_RESET;
      lim_r       <= mlo_pkg::LIMIT_RESET;
      yaw_r       <= '0;
      pitch_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mlo_pkg::REG_SENSITIVITY: sens_r <= cfg_data[mlo_pkg::SENS_W-1:0];
          mlo_pkg::REG_PITCH_LIMIT: lim_r  <= cfg_data[mlo_pkg::LIMIT_W-1:0];
        endcase
      end
      if (accept && in_cmd == mlo_pkg::CMD_CAPTURE) flag_r <= in_capture_value;
      if (st_r == mlo_pkg::ST_MUL_Y && upd_r) yaw_r <= yaw_r + prod_r[31:0];
      if (st_r == mlo_pkg::ST_UPDATE) begin
        if (upd_r) begin
          pitch_r <= clamp_pitch(pitch_upd, lim_r);
        end else if (cmd_r == mlo_pkg::CMD_LOAD) begin
          yaw_r   <= ly_r;
          pitch_r <= clamp_pitch({{32{lp_r[31]}}, lp_r}, lim_r);
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      dx_r  <= in_delta_x;
      dy_r  <= in_delta_y;
      ly_r  <= in_load_yaw;
      lp_r  <= in_load_pitch;
      upd_r <= (in_cmd == mlo_pkg::CMD_UPDATE) && flag_r;
      if (flag_r) act_r <= in_escape_pressed ? mlo_pkg::ACT_DISABLE : mlo_pkg::ACT_NONE;
      else act_r <= in_left_pressed ? mlo_pkg::ACT_ENABLE : mlo_pkg::ACT_NONE;
    end
    if (st_r == mlo_pkg::ST_CY_WAIT && cordic_done) begin
      cy_r <= c_val;
      sy_r <= s_val;
    end
    if (st_r == mlo_pkg::ST_CP_WAIT && cordic_done) begin
      cp_r <= c_val;
      sp_r <= s_val;
    end
    if (st_r == mlo_pkg::ST_MUL_CC) fx_r <= to_out(q30_ext);
    if (st_r == mlo_pkg::ST_PROD_CC) fz_r <= to_out(-q30_ext);
    if (out_load) begin
      oact_r   <= act_r;
      ocap_r   <= flag_r;
      oyaw_r   <= yaw_r;
      opitch_r <= pitch_r;
      ofx_r    <= fx_r;
      ofy_r    <= to_out({{2{sp_r[mlo_pkg::CS_W-1]}}, sp_r});
      ofz_r    <= fz_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_capture_action = oact_r;
  assign out_capture_on     = ocap_r;
  assign out_yaw_out        = oyaw_r;
  assign out_pitch_out      = opitch_r;
  assign out_forward_x      = ofx_r;
  assign out_forward_y      = ofy_r;
  assign out_forward_z      = ofz_r;

endmodule

// ===== design/mlo_checker.sv =====
module mlo_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_capture_action,
  input logic signed [31:0]  out_yaw_out,
  input logic signed [15:0]  out_forward_x
);

  // sequencer is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after a request was accepted");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_capture_action == mlo_pkg::ACT_NONE)
                   || (out_capture_action == mlo_pkg::ACT_ENABLE)
                   || (out_capture_action == mlo_pkg::ACT_DISABLE)))
    else $error("capture action holds an unused code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_yaw_out)
                                   && $stable(out_forward_x)))
    else $error("stalled result changed or dropped");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind mouse_look_orientation_core mlo_checker u_mlo_checker (.*);
